// File: sv/qea_pkg.sv
`default_nettype none
package qea_pkg;
   localparam int SMOOTH_DEPTH = 8;
   localparam int RING_AW = 3;
   localparam int FILL_W = 4;
   localparam logic [31:0] RPM_NUM = 32'd3000000;
   // ceil(2^36 / 125), exact quotient for any 29-bit dividend
   localparam logic [29:0] MS_RECIP = 30'd549755814;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_RESTART = 2'd1,
      FUNC_DIR = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_LATCH_MODE = 2'd0,
      CSR_DEBOUNCE = 2'd1,
      CSR_FAST = 2'd2,
      CSR_MEDIUM = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NEWEST, ST_CHECK, ST_COMMIT, ST_CLEAR, ST_SUM, ST_SUMACC,
      ST_AVG, ST_RPM, ST_MS, ST_OUT
   } state_type;

   function automatic logic [1:0] step_code(input logic [3:0] idx);
      // 0 none, 1 plus, 2 minus
      logic [1:0] r;
      begin
         unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: r = 2'd2;
            4'd2, 4'd4, 4'd11, 4'd13: r = 2'd1;
            default: r = 2'd0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// File: sv/qea_divider.sv
`default_nettype none
module qea_divider
   import qea_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [34:0] dividend,
   input wire logic [31:0] divisor,
   output logic busy,
   output logic [34:0] quotient
);
   logic [34:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[31:0], q_ff[34]};
      diff = {1'b0, trial} - {2'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 6'd35;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!diff[33]) begin
            r_in = diff[32:0];
            q_in = {q_ff[33:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[33:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != 6'd0);
   assign quotient = q_ff;
endmodule
`default_nettype wire

// File: sv/quadrature_encoder_accel_rpm_unit.sv
`default_nettype none
// flow: the accepting req edge starts a walk over the filled ring entries, then two 35-step
// divisions run one after another, and ST_MS and ST_OUT register the result before rsp_tvalid
// throughput: one word in flight; the next req word is taken the cycle after the rsp word
// leaves
// reset: synchronous, active high; control and state registers take reset values, the 8-entry ring is read
// through its fill count so it needs no clearing pass
module quadrature_encoder_accel_rpm_unit
   import qea_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [1:0] req_tuser, // func
   input wire logic [39:0] req_tdata, // level_a, level_b, now_us
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [79:0] rsp_tdata, // position, direction, interval_ms, rpm
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [1:0] csr_index,
   input wire logic [19:0] csr_data
);
   logic [31:0] ring_mem [SMOOTH_DEPTH];
   logic [31:0] rd_ff;
   logic [RING_AW-1:0] rd_addr;
   logic wr_en;
   logic [RING_AW-1:0] wr_addr;
   logic [31:0] wr_data;

   logic [1:0] mode_ff;
   logic [15:0] deb_ff;
   logic [19:0] fast_ff, med_ff;
   logic [1:0] prev_ff;
   logic [31:0] raw_ff, det_ff, rep_ff, last_ff, prior_ff;
   logic [RING_AW-1:0] widx_ff;
   logic [FILL_W-1:0] fill_ff;

   state_type st_ff, st_in;
   logic [31:0] now_ff, diff_ff;
   logic [1:0] dir_ff;
   logic [34:0] sum_ff;
   logic [FILL_W-1:0] i_ff;
   logic [31:0] avg_ff;
   logic [22:0] ms_ff;
   logic [21:0] rpm_ff;
   logic [79:0] out_ff;
   logic out_v_ff;
   logic [1:0] div_sel_ff;

   logic div_start, div_busy;
   logic [34:0] div_num, div_q;
   logic [31:0] div_den;

   qea_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .busy(div_busy), .quotient(div_q)
   );

   func_type fn;
   logic [1:0] pins;
   logic [31:0] now_w, diff_w, dabs, newest;
   logic latched;
   logic [1:0] sc;
   logic [31:0] raw_n;
   logic [31:0] base, delta;
   logic [31:0] span;
   logic [58:0] ms_prod;

   assign fn = func_type'(req_tuser);
   assign pins = {req_tdata[1], req_tdata[0]};
   assign now_w = req_tdata[33:2];
   assign csr_ready = 1'b1;
   assign req_tready = (st_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;
   assign diff_w = now_w - last_ff;
   assign sc = step_code({prev_ff, pins});
   assign raw_n = (sc == 2'd1) ? raw_ff + 32'd1 : (sc == 2'd2) ? raw_ff - 32'd1 : raw_ff;
   assign newest = rd_ff;
   assign dabs = (diff_ff > newest) ? diff_ff - newest : newest - diff_ff;
   assign base = (mode_ff == 2'd2) ? {raw_ff[31], raw_ff[31:1]} : {{2{raw_ff[31]}}, raw_ff[31:2]};
   assign delta = base - det_ff;
   // ms = floor((span / 8) / 125) through a scaled reciprocal
   assign span = last_ff - prior_ff;
   assign ms_prod = {30'd0, span[31:3]} * {29'd0, MS_RECIP};

   always_comb begin
      unique case (pins)
         2'd3: latched = (mode_ff == 2'd0) || (mode_ff == 2'd2);
         2'd0: latched = (mode_ff == 2'd1) || (mode_ff == 2'd2);
         default: latched = 1'b0;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            if (fn == FUNC_SAMPLE && pins != prev_ff && latched && diff_w >= {16'd0, deb_ff})
               st_in = ST_NEWEST;
            else
               st_in = ST_SUM;
         end
         ST_NEWEST: st_in = ST_CHECK;
         ST_CHECK: st_in = ST_COMMIT;
         ST_COMMIT: st_in = ST_SUM;
         ST_CLEAR: st_in = ST_SUM;
         ST_SUM: st_in = ST_SUMACC;
         ST_SUMACC: st_in = (i_ff + 4'd1 >= fill_ff) ? ST_AVG : ST_SUMACC;
         ST_AVG: if (!div_busy && div_sel_ff == 2'd1) st_in = ST_RPM;
         ST_RPM: if (!div_busy && div_sel_ff == 2'd2) st_in = ST_MS;
         ST_MS: st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num = {3'd0, span};
      div_den = 32'd1000;
      unique case (st_ff)
         ST_AVG: if (div_sel_ff == 2'd0) begin
            div_start = 1'b1;
            div_num = sum_ff;
            div_den = {28'd0, fill_ff};
         end
         ST_RPM: if (div_sel_ff == 2'd1) begin
            div_start = 1'b1;
            div_num = {3'd0, RPM_NUM};
            div_den = (avg_ff == 32'd0) ? 32'd1 : avg_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   always_comb begin
      rd_addr = widx_ff - RING_AW'(1);
      if (st_ff == ST_SUMACC)
         rd_addr = widx_ff - RING_AW'(2) - i_ff[RING_AW-1:0];
      wr_en = (st_ff == ST_COMMIT);
      wr_addr = widx_ff;
      wr_data = diff_ff;
   end

   always_ff @(posedge clock) begin
      rd_ff <= ring_mem[rd_addr];
      if (wr_en) ring_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; deb_ff <= 16'd1000; fast_ff <= 20'd5000; med_ff <= 20'd15000;
         prev_ff <= 2'd3; raw_ff <= '0; det_ff <= '0; rep_ff <= '0;
         last_ff <= '0; prior_ff <= '0; widx_ff <= '0; fill_ff <= '0;
         st_ff <= ST_IDLE; out_v_ff <= 1'b0; div_sel_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_valid) begin
            unique case (csr_idx_type'(csr_index))
               CSR_LATCH_MODE: mode_ff <= csr_data[1:0];
               CSR_DEBOUNCE: deb_ff <= csr_data[15:0];
               CSR_FAST: fast_ff <= csr_data;
               CSR_MEDIUM: med_ff <= csr_data;
               default: mode_ff <= mode_ff;
            endcase
         end
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               now_ff <= now_w;
               diff_ff <= diff_w;
               dir_ff <= 2'd0;
               div_sel_ff <= 2'd0;
               unique case (fn)
                  FUNC_SAMPLE: if (pins != prev_ff) begin
                     raw_ff <= raw_n;
                     prev_ff <= pins;
                  end
                  FUNC_RESTART: begin
                     prev_ff <= pins; last_ff <= now_w; prior_ff <= now_w;
                     raw_ff <= '0; det_ff <= '0; rep_ff <= '0;
                     widx_ff <= '0; fill_ff <= '0;
                  end
                  FUNC_DIR: begin
                     if ($signed(rep_ff) < $signed(det_ff)) dir_ff <= 2'd1;
                     else if ($signed(rep_ff) > $signed(det_ff)) dir_ff <= 2'd2;
                     rep_ff <= det_ff;
                  end
                  default: dir_ff <= 2'd0;
               endcase
            end
            ST_CHECK: begin
               if (fill_ff != '0 && newest != '0 && dabs * 32'd100 > newest * 32'd30)
                  fill_ff <= '0;
            end
            ST_COMMIT: begin
               if (fill_ff < FILL_W'(SMOOTH_DEPTH)) fill_ff <= fill_ff + FILL_W'(1);
               widx_ff <= widx_ff + RING_AW'(1);
               if (diff_ff < {12'd0, fast_ff}) det_ff <= det_ff + {delta[29:0], 2'b0};
               else if (diff_ff < {12'd0, med_ff}) det_ff <= det_ff + {delta[30:0], 1'b0};
               else det_ff <= base;
               prior_ff <= last_ff;
               last_ff <= now_ff;
            end
            ST_SUM: begin
               sum_ff <= '0;
               i_ff <= '0;
            end
            ST_SUMACC: begin
               if (i_ff < fill_ff) sum_ff <= sum_ff + {3'd0, rd_ff};
               i_ff <= i_ff + FILL_W'(1);
            end
            ST_AVG: begin
               if (div_sel_ff == 2'd0) div_sel_ff <= 2'd1;
               else if (!div_busy) avg_ff <= (fill_ff == '0) ? 32'd0 : div_q[31:0];
            end
            ST_RPM: begin
               if (div_sel_ff == 2'd1) div_sel_ff <= 2'd2;
               else if (!div_busy) rpm_ff <= (avg_ff == '0) ? 22'd0 : div_q[21:0];
            end
            ST_MS: begin
               ms_ff <= ms_prod[58:36];
            end
            ST_OUT: begin
               out_ff <= {1'b0, rpm_ff, ms_ff, dir_ff, det_ff};
               out_v_ff <= 1'b1;
            end
            default: dir_ff <= dir_ff;
         endcase
      end
   end
endmodule
`default_nettype wire
